// ===== hdl/wgm_pkg.sv =====
// Shared types and constants of the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_VALUE   = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] GLOB_ANY_RUN = 8'h2A;
    localparam logic [7:0] GLOB_ANY_ONE = 8'h3F;

    // Depth of the queue between the front and the back part.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_VALUE,
        OP_REPORT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_entry;

endpackage : wgm_pkg

`default_nettype wire

// ===== hdl/wgm_ifs.sv =====
// Channel interfaces of the wildcard glob matcher: input beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output command, output data_byte, output last,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input last,
                    output ready);
endinterface : wgm_in_if

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_too_long;

    modport source (output valid, output matched, output pattern_too_long,
                    input ready);
    modport sink   (input valid, input matched, input pattern_too_long,
                    output ready);
endinterface : wgm_out_if

`default_nettype wire

// ===== hdl/wgm_front.sv =====
// Front part: accepts input beats, decodes the command and registers one entry.
`timescale 1ns / 1ps
`default_nettype none

module wgm_front
    import wgm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wgm_in_if.sink      i_in,
    output logic        o_valid,
    output t_entry      o_entry,
    input  wire logic   i_ready
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_take;
    logic   w_keep;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;

    // Decode the command; the unused code is accepted and dropped here.
    always_comb begin
        n_valid = r_valid && !i_ready;
        n_entry = r_entry;
        w_keep  = 1'b1;
        if (w_take) begin
            n_entry.data = i_in.data_byte;
            n_entry.last = i_in.last;
            case (i_in.command)
                CMD_PATTERN: n_entry.op = OP_PATTERN;
                CMD_VALUE:   n_entry.op = OP_VALUE;
                CMD_REPORT:  n_entry.op = OP_REPORT;
                default: begin
                    n_entry.op = OP_VALUE;
                    w_keep     = 1'b0;
                end
            endcase
            n_valid = w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule : wgm_front

`default_nettype wire

// ===== hdl/wgm_queue.sv =====
// Short queue of decoded entries between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module wgm_queue
    import wgm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_ready,
    output logic        o_valid,
    output t_entry      o_entry,
    input  wire logic   i_pop
);

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule : wgm_queue

`default_nettype wire

// ===== hdl/wgm_back.sv =====
// Back part: pattern store, live position vector and the result register.
`timescale 1ns / 1ps
`default_nettype none

module wgm_back
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    wgm_out_if.source   o_out
);

    localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int unsigned LEVELS = $clog2(PATTERN_MAX + 1);

    logic [7:0]             r_store [PATTERN_MAX];
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   r_ovf;
    logic                   n_ovf;
    logic                   r_complete;
    logic                   n_complete;
    logic [PATTERN_MAX:0]   r_live;
    logic [PATTERN_MAX:0]   n_live;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_matched;
    logic                   n_matched;
    logic                   r_too_long;
    logic                   n_too_long;

    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_step;
    logic [PATTERN_MAX:0]   w_g [LEVELS+1];
    logic [PATTERN_MAX:0]   w_p [LEVELS+1];
    logic [PATTERN_MAX:0]   w_closed;
    logic [PATTERN_MAX:0]   w_advanced;
    logic [LEN_W-1:0]       w_base;
    logic                   w_wr_en;
    logic                   w_out_free;

    // Per-position classification against the current value byte.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_star[i] = (LEN_W'(i) < r_len) && (r_store[i] == GLOB_ANY_RUN);
            w_step[i] = (LEN_W'(i) < r_len) && (r_store[i] != GLOB_ANY_RUN)
                        && ((r_store[i] == GLOB_ANY_ONE) || (r_store[i] == i_entry.data));
        end
    end

    // Closure over star runs as a parallel prefix: a live bit carries forward
    // through every following position whose predecessor is a star.
    always_comb begin
        w_g[0] = r_live;
        w_p[0] = {w_star, 1'b0};
        for (int k = 0; k < LEVELS; k++) begin
            for (int j = 0; j <= PATTERN_MAX; j++) begin
                if (j >= (1 << k)) begin
                    w_g[k+1][j] = w_g[k][j] | (w_p[k][j] & w_g[k][j - (1 << k)]);
                    w_p[k+1][j] = w_p[k][j] & w_p[k][j - (1 << k)];
                end else begin
                    w_g[k+1][j] = w_g[k][j];
                    w_p[k+1][j] = w_p[k][j];
                end
            end
        end
        w_closed = w_g[LEVELS];
    end

    // One value byte: a star keeps its position, a match moves one forward.
    always_comb begin
        w_advanced = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            w_advanced[j]   = w_advanced[j] | (w_closed[j] & w_star[j]);
            w_advanced[j+1] = w_closed[j] & w_step[j];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = i_valid && ((i_entry.op != OP_REPORT) || w_out_free);
    assign w_base     = r_complete ? '0 : r_len;

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_complete  = r_complete;
        n_live      = r_live;
        n_out_valid = r_out_valid && !o_out.ready;
        n_matched   = r_matched;
        n_too_long  = r_too_long;
        w_wr_en     = 1'b0;
        if (o_pop) begin
            case (i_entry.op)
                OP_PATTERN: begin
                    n_ovf = r_complete ? 1'b0 : r_ovf;
                    if (w_base < LEN_W'(PATTERN_MAX)) begin
                        w_wr_en = 1'b1;
                        n_len   = w_base + LEN_W'(1);
                    end else begin
                        n_len = w_base;
                        n_ovf = 1'b1;
                    end
                    n_complete = i_entry.last;
                    n_live     = {{PATTERN_MAX{1'b0}}, 1'b1};
                end
                OP_VALUE: begin
                    n_live = w_advanced;
                end
                OP_REPORT: begin
                    n_out_valid = 1'b1;
                    n_matched   = w_closed[r_len] && !r_ovf;
                    n_too_long  = r_ovf;
                    n_live      = {{PATTERN_MAX{1'b0}}, 1'b1};
                end
                default: begin
                    n_live = r_live;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_complete  <= 1'b1;
            r_live      <= {{PATTERN_MAX{1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_complete  <= n_complete;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
        r_matched  <= n_matched;
        r_too_long <= n_too_long;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_base[IDX_W-1:0]] <= i_entry.data;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_too_long = r_too_long;

endmodule : wgm_back

`default_nettype wire

// ===== hdl/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher: front, queue and back part.
`timescale 1ns / 1ps
`default_nettype none

// The matcher takes a glob pattern one byte per beat (command 0, with last on
// the final byte) and then any number of values one byte per beat (command 1),
// each closed by a report beat (command 2) that yields one result beat with
// matched and pattern_too_long. A '*' in the pattern matches any run of bytes,
// including none, a '?' matches exactly one byte, and every other byte must be
// equal. The block sustains one input beat per clock unless a report stalls
// behind a waiting result: every stored pattern position is updated in
// parallel for each value byte, and the combinational update of the live
// position vector, a parallel prefix over runs of stars, sets that figure. A
// report beat passes the front register, the queue and the result register;
// a result waiting on the output does not stop input beats from flowing, only a
// second report stalls behind it. A pattern byte that arrives while a value is
// in progress restarts that value, and a value may be matched against a
// pattern that is still being loaded. A pattern with more than PATTERN_MAX
// bytes keeps its first PATTERN_MAX bytes and reports pattern_too_long with
// matched low. Command code 3 is accepted and ignored. There is no clearing
// pass after reset: the pattern store is only read below its fill count.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wgm_in_if.sink      i_in,
    wgm_out_if.source   o_out
);

    logic   w_f_valid;
    t_entry w_f_entry;
    logic   w_q_ready;
    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_pop;

    // The front decodes commands into entries and registers one of them.
    wgm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .o_entry (w_f_entry),
        .i_ready (w_q_ready)
    );

    // The queue lets the front keep accepting while the back waits on a result.
    wgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_entry (w_f_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    // The back holds the pattern and the live positions and drives results.
    wgm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // The back only takes an entry that the queue actually holds.
    a_pop_from_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("entry taken from an empty queue");

    // A report taken from the queue shows up as a result beat next cycle.
    a_report_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_q_valid && (w_q_entry.op == OP_REPORT)) |=> o_out.valid)
        else $error("report entry produced no result beat");

    // An overflowed pattern never reports a match.
    a_no_match_on_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.matched && o_out.pattern_too_long))
        else $error("match reported for an overflowed pattern");

endmodule : wildcard_glob_matcher

`default_nettype wire

// ===== tb/wildcard_glob_matcher_tb.sv =====
// Self-checking testbench of the wildcard glob matcher: directed table, random glob traffic.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher_tb
    import wgm_pkg::*;
();

    localparam int unsigned PMAX = 64;
    // Command code 3 has no meaning; the block must swallow it silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Long enough for the two-entry queue and the result register to fill up.
    localparam int unsigned HOLD_CYCLES = 120;
    // Cycles to wait once nothing is outstanding; the report path is three deep.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_BEATS = 525;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic matched;
        logic too_long;
    } t_match_report;

    // One row of the directed table. A pinned row carries a result that is
    // obvious by inspection; every other report row is left to the predictor.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic       pin_matched;
        logic       pin_too_long;
    } t_directed_row;

    localparam int unsigned N_DIRECTED = 30;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wgm_in_if  in_bus ();
    wgm_out_if out_bus ();

    // Side-band that travels with each input beat so the monitor knows
    // whether a report row of the table has a hand-typed answer.
    logic tb_pinned;
    logic tb_pin_matched;
    logic tb_pin_too_long;

    wildcard_glob_matcher #(
        .PATTERN_MAX(PMAX)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the matcher state, updated on every accepted beat.
    logic [7:0]    pat_bytes [PMAX];
    int unsigned   pat_fill = 0;
    bit            pat_ovf = 1'b0;
    bit            pat_closed = 1'b1;
    bit [PMAX:0]   live_pos = 1;

    t_match_report pending_reports[$];
    int unsigned   fail_count = 0;
    int unsigned   beats_sent = 0;

    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    bit            long_hold_req = 1'b0;
    int unsigned   hold_left = 0;

    t_directed_row directed_rows [0:N_DIRECTED-1] = '{
        // Empty pattern after reset: only the empty value matches.
        '{CMD_REPORT,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{CMD_VALUE,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // Report ignores its data byte and last flag.
        '{CMD_REPORT,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
        // The unused code must neither report nor disturb the state.
        '{CMD_UNUSED,  8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_UNUSED,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        // A lone star against the empty value and a two-byte value.
        '{CMD_PATTERN, GLOB_ANY_RUN, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // Pattern "?*\xFF": one byte, any run, then a literal 0xFF.
        '{CMD_PATTERN, GLOB_ANY_ONE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_PATTERN, GLOB_ANY_RUN, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   GLOB_ANY_ONE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // A pattern beat in the middle of a value restarts that value.
        '{CMD_VALUE,   8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_PATTERN, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // A value is matched against a pattern that is still being loaded.
        '{CMD_PATTERN, 8'h42, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h42, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_PATTERN, GLOB_ANY_RUN, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h42, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_VALUE,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_REPORT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    // Spread live positions forward over stars, since a star may match nothing.
    function automatic bit [PMAX:0] star_closure(bit [PMAX:0] v);
        for (int i = 0; i < pat_fill; i++) begin
            if (v[i] && pat_bytes[i] == GLOB_ANY_RUN) begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] pick_glob_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61;
            3, 4:    return 8'h62;
            5, 6:    return GLOB_ANY_RUN;
            7:       return GLOB_ANY_ONE;
            8:       return 8'h63;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_value_byte();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h61;
            3, 4:    return 8'h62;
            5:       return 8'h63;
            default: return 8'($urandom());
        endcase
    endfunction

    // Builds a value that matches the given pattern: each star becomes a
    // short random run and each question mark one random byte.
    function automatic t_byte_q expand_pattern(t_byte_q pat);
        t_byte_q v;
        for (int i = 0; i < pat.size() && i < PMAX; i++) begin
            if (pat[i] == GLOB_ANY_RUN) begin
                repeat ($urandom_range(0, 3)) v = {v, pick_value_byte()};
            end else if (pat[i] == GLOB_ANY_ONE) begin
                v = {v, 8'($urandom())};
            end else begin
                v = {v, pat[i]};
            end
        end
        return v;
    endfunction

    // Offers one beat and returns at the edge where it is taken. The sender
    // may idle first; valid then drops for whole cycles only.
    task automatic drive_beat(input logic [1:0] cmd, input logic [7:0] data,
                              input logic last_flag, input logic pinned = 1'b0,
                              input logic pin_m = 1'b0, input logic pin_t = 1'b0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.command   <= cmd;
        in_bus.data_byte <= data;
        in_bus.last      <= last_flag;
        tb_pinned        <= pinned;
        tb_pin_matched   <= pin_m;
        tb_pin_too_long  <= pin_t;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Sends a value byte by byte and closes it with a report beat. The last
    // flag and the report's data byte are random because the block ignores them.
    task automatic send_value(t_byte_q v);
        foreach (v[i]) begin
            drive_beat(CMD_VALUE, v[i], 1'($urandom_range(0, 1)));
        end
        drive_beat(CMD_REPORT, 8'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_some_value(t_byte_q pat);
        t_byte_q v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            v = expand_pattern(pat);
        end else if (pick < 80) begin
            // Near miss: a matching value with one byte changed or one dropped, or one byte if empty.
            v = expand_pattern(pat);
            if (v.size() == 0) begin
                v = {v, pick_value_byte()};
            end else if ($urandom_range(0, 1) == 0) begin
                v[$urandom_range(0, v.size() - 1)] = pick_value_byte();
            end else begin
                void'(v.pop_back());
            end
        end else begin
            repeat ($urandom_range(0, 10)) v = {v, pick_value_byte()};
        end
        send_value(v);
    endtask

    // One random stretch of traffic: mostly a pattern followed by a few
    // values, sometimes a value cut into the pattern load, sometimes noise.
    task automatic run_glob_sequence();
        t_byte_q pat;
        int unsigned plen;
        int unsigned split_at;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // Noise: any command, any byte, any last flag.
            repeat ($urandom_range(1, 4)) begin
                drive_beat(2'($urandom_range(0, 3)), 8'($urandom()),
                           1'($urandom_range(0, 1)));
            end
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
            plen = $urandom_range(1, 8);
        end else if (pick < 98) begin
            plen = $urandom_range(9, 40);
        end else begin
            plen = $urandom_range(PMAX - 4, PMAX + 6);
        end
        repeat (plen) pat = {pat, pick_glob_byte()};
        split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plen) : plen;
        for (int i = 0; i < plen; i++) begin
            drive_beat(CMD_PATTERN, pat[i], i == plen - 1);
            if (i + 1 == split_at && split_at < plen) begin
                send_some_value(pat[0:split_at-1]);
            end
        end
        repeat ($urandom_range(1, 5)) begin
            // Now and then a value is broken off by a stray pattern beat.
            if ($urandom_range(0, 99) < 5) begin
                drive_beat(CMD_VALUE, pick_value_byte(), 1'b0);
                drive_beat(CMD_PATTERN, pick_glob_byte(), 1'($urandom_range(0, 1)));
            end
            send_some_value(pat);
        end
    endtask

    // Lets everything outstanding come out. The first edge gives the monitor
    // time to log a report taken at the current edge.
    task automatic drain_reports();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            out_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: checks result beats against the oldest expectation, then
    // runs every accepted input beat through the shadow matcher.
    always @(posedge i_clk) begin : monitor
        t_match_report want;
        bit [PMAX:0] reach;
        bit [PMAX:0] nxt;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result beat with no report outstanding");
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (out_bus.matched !== want.matched) begin
                        $error("matched: expected %0b, got %0b",
                               want.matched, out_bus.matched);
                        fail_count++;
                    end
                    if (out_bus.pattern_too_long !== want.too_long) begin
                        $error("pattern_too_long: expected %0b, got %0b",
                               want.too_long, out_bus.pattern_too_long);
                        fail_count++;
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                case (in_bus.command)
                    CMD_PATTERN: begin
                        // A finished pattern is replaced by the next pattern byte.
                        if (pat_closed) begin
                            pat_fill = 0;
                            pat_ovf = 1'b0;
                            pat_closed = 1'b0;
                        end
                        if (pat_fill < PMAX) begin
                            pat_bytes[pat_fill] = in_bus.data_byte;
                            pat_fill++;
                        end else begin
                            pat_ovf = 1'b1;
                        end
                        if (in_bus.last) begin
                            pat_closed = 1'b1;
                        end
                        live_pos = 1;
                    end
                    CMD_VALUE: begin
                        reach = star_closure(live_pos);
                        nxt = '0;
                        for (int i = 0; i < pat_fill; i++) begin
                            if (reach[i]) begin
                                if (pat_bytes[i] == GLOB_ANY_RUN) begin
                                    nxt[i] = 1'b1;
                                end else if (pat_bytes[i] == GLOB_ANY_ONE ||
                                             pat_bytes[i] == in_bus.data_byte) begin
                                    nxt[i+1] = 1'b1;
                                end
                            end
                        end
                        live_pos = nxt;
                    end
                    CMD_REPORT: begin
                        reach = star_closure(live_pos);
                        if (tb_pinned) begin
                            want.matched  = tb_pin_matched;
                            want.too_long = tb_pin_too_long;
                        end else begin
                            want.matched  = reach[pat_fill] && !pat_ovf;
                            want.too_long = pat_ovf;
                        end
                        pending_reports = {pending_reports, want};
                        live_pos = 1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    initial begin
        in_bus.valid     = 1'b0;
        in_bus.command   = CMD_PATTERN;
        in_bus.data_byte = 8'h00;
        in_bus.last      = 1'b0;
        out_bus.ready    = 1'b0;
        tb_pinned        = 1'b0;
        tb_pin_matched   = 1'b0;
        tb_pin_too_long  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with mild idling on both sides.
        send_idle_pct = 10;
        recv_idle_pct = 10;
        foreach (directed_rows[r]) begin
            drive_beat(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].last,
                       directed_rows[r].pinned, directed_rows[r].pin_matched,
                       directed_rows[r].pin_too_long);
        end
        // Exactly full store: 63 stars and a final 0x00, matched by "\x00".
        for (int i = 0; i < PMAX; i++) begin
            drive_beat(CMD_PATTERN, (i == PMAX - 1) ? 8'h00 : GLOB_ANY_RUN, i == PMAX - 1);
        end
        drive_beat(CMD_VALUE, 8'h00, 1'b0);
        drive_beat(CMD_REPORT, 8'h00, 1'b0);
        // One byte too many: the overflow flag wins over any match.
        for (int i = 0; i <= PMAX; i++) begin
            drive_beat(CMD_PATTERN, GLOB_ANY_RUN, i == PMAX);
        end
        drive_beat(CMD_REPORT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        drain_reports();

        // Random part in three idling phases; the sender pauses between
        // phases until every report is back.
        send_idle_pct = 22;
        recv_idle_pct = 79;
        begin : phase_slow_receiver
            int unsigned stop_at;
            stop_at = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at) run_glob_sequence();
        end
        drain_reports();

        send_idle_pct = 79;
        recv_idle_pct = 22;
        begin : phase_slow_sender
            int unsigned stop_at;
            stop_at = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at) run_glob_sequence();
        end
        drain_reports();

        // Full speed on both sides, with long receiver hold-offs so that
        // the internal queue fills and input beats get stalled.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        begin : phase_full_rate
            int unsigned stop_at;
            bit second_hold;
            stop_at = beats_sent + PHASE_BEATS;
            second_hold = 1'b0;
            while (beats_sent < stop_at) begin
                run_glob_sequence();
                if (!second_hold && beats_sent + PHASE_BEATS / 2 >= stop_at) begin
                    second_hold = 1'b1;
                    long_hold_req = 1'b1;
                end
            end
        end
        drain_reports();

        if (fail_count == 0) begin
            $display("** wildcard_glob_matcher: PASSED **");
        end else begin
            $display("** wildcard_glob_matcher: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #10ms;
        $display("** wildcard_glob_matcher: FAILED **");
        $finish;
    end

endmodule : wildcard_glob_matcher_tb

`default_nettype wire
